// ===== src/cgee_pkg.sv =====
// shared constants, types and register codes for the cg energy-error stop check
// no dependencies; compiled first

package cgee_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam int DATA_W  = 32;
    localparam int TERM_W  = 56;
    localparam int WSUM_W  = 60;
    localparam int ESUM_W  = 64;
    localparam int COUNT_W = 20;
    localparam int LOOK_W  = 5;
    localparam int ACC_W   = 128;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REL_TOL    = 3'd0,
        CFG_EPS_FLOOR  = 3'd1,
        CFG_ABS_TOL    = 3'd2,
        CFG_MAX_STEPS  = 3'd3,
        CFG_LOOK_AHEAD = 3'd4,
        CFG_MIN_TOL    = 3'd5
    } cfg_reg_t;

    localparam logic [DATA_W-1:0]  RST_REL_TOL    = 32'd42950;
    localparam logic [DATA_W-1:0]  RST_EPS_FLOOR  = 32'd1;
    localparam logic [DATA_W-1:0]  RST_ABS_TOL    = 32'd0;
    localparam logic [COUNT_W-1:0] RST_MAX_STEPS  = 20'd1000;
    localparam logic [LOOK_W-1:0]  RST_LOOK_AHEAD = 5'd16;
    localparam logic [DATA_W-1:0]  RST_MIN_TOL    = 32'd0;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } mac_shift_t;

    typedef struct packed {
        logic       en;
        logic       clr;
        mac_shift_t sh;
    } mac_op_t;

endpackage

// ===== src/cgee_req_if.sv =====
// request channel: one cg iteration update or a clear per transaction
// depends on cgee_pkg

interface cgee_req_if;
    import cgee_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic        [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] q_aq;
    logic        [DATA_W-1:0] r_pinv_r;

    modport source (output valid, req_type, alpha, q_aq, r_pinv_r, input ready);
    modport sink   (input valid, req_type, alpha, q_aq, r_pinv_r, output ready);
endinterface

// ===== src/cgee_rsp_if.sv =====
// response channel: stop flags and iteration count per transaction
// depends on cgee_pkg

interface cgee_rsp_if;
    import cgee_pkg::*;

    logic               valid;
    logic               ready;
    logic               stop;
    logic               vanishing_step;
    logic               min_decrease_reached;
    logic [COUNT_W-1:0] iteration_count;

    modport source (output valid, stop, vanishing_step, min_decrease_reached,
                    iteration_count, input ready);
    modport sink   (input valid, stop, vanishing_step, min_decrease_reached,
                    iteration_count, output ready);
endinterface

// ===== src/cgee_mac.sv =====
// shared 32x32 multiplier with a 128-bit shifted accumulator
// depends on cgee_pkg

module cgee_mac (
    input  logic                          clk,
    input  cgee_pkg::mac_op_t             op,
    input  logic [cgee_pkg::DATA_W-1:0]   a,
    input  logic [cgee_pkg::DATA_W-1:0]   b,
    output logic [cgee_pkg::ACC_W-1:0]    acc
);
    import cgee_pkg::*;

    logic [2*DATA_W-1:0] prod;
    logic [ACC_W-1:0]    prod_sh;
    logic [ACC_W-1:0]    base;
    logic [ACC_W-1:0]    acc_reg;

    assign prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    assign base = op.clr ? '0 : acc_reg;

    always_comb
    begin
        case (op.sh)
            SH_0:    prod_sh = {64'd0, prod};
            SH_32:   prod_sh = {32'd0, prod, 32'd0};
            SH_64:   prod_sh = {prod, 64'd0};
            default: prod_sh = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= base + prod_sh;
        end
    end

    assign acc = acc_reg;
endmodule

// ===== src/cg_energy_error_stop_check.sv =====
// top level of the cg energy-error stop check: sequencer, state and flag logic
// depends on cgee_pkg, cgee_req_if, cgee_rsp_if and cgee_mac

// One transaction in, one out. An update sums n window terms, where n is at most the
// look-ahead and at most 16; a clear sums none. All products go through one shared
// 32x32 multiplier: the 64x64 ratio products of the three ratio tests are built from
// four partial products each, and the window sum reads the term ring one entry a cycle.
// The next request is taken as soon as the result sits in the output register; a result
// still waiting there holds the block in its last step until it is taken.
module cg_energy_error_stop_check (
    input  logic                              clk,
    input  logic                              rst_n,
    cgee_req_if.sink                          req,
    cgee_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [cgee_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cgee_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cgee_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_WSUM,
        ST_SQ,
        ST_SQL,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_CMP,
        ST_ABS,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        RT_STOP = 2'd0,
        RT_MIN  = 2'd1,
        RT_VAN  = 2'd2
    } ratio_t;

    state_t             state_reg;
    ratio_t             k_reg;
    logic [2:0]         flags_reg;

    logic [DATA_W-1:0]  rel_tol_reg;
    logic [DATA_W-1:0]  eps_floor_reg;
    logic [DATA_W-1:0]  abs_tol_reg;
    logic [COUNT_W-1:0] max_steps_reg;
    logic [LOOK_W-1:0]  look_ahead_reg;
    logic [DATA_W-1:0]  min_tol_reg;

    logic [TERM_W-1:0]  ring [MAX_WINDOW];
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   rd_reg;
    logic [TERM_W-1:0]  rd_data_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   issued_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [ESUM_W-1:0]  energy_reg;
    logic [DATA_W-1:0]  step_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [63:0]        sq_reg;

    logic               out_valid_reg;
    logic               out_stop_reg;
    logic               out_van_reg;
    logic               out_min_reg;
    logic [COUNT_W-1:0] out_count_reg;

    mac_op_t            mac_op;
    logic [DATA_W-1:0]  mac_a;
    logic [DATA_W-1:0]  mac_b;
    logic [ACC_W-1:0]   acc;

    logic               accept;
    logic [TERM_W-1:0]  term;
    logic [ESUM_W:0]    energy_sum;
    logic [COUNT_W-1:0] len;
    logic [CNT_W-1:0]   n_terms;
    logic [DATA_W-1:0]  q_sel;
    logic [63:0]        cmp_lhs;
    logic               cmp_lt;
    logic               stop_flag;
    logic               min_flag;
    logic               van_flag;
    logic [IDX_W-1:0]   ptr_inc;
    logic [IDX_W-1:0]   rd_dec;

    cgee_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign term       = acc[63:8];
    assign energy_sum = {1'b0, energy_reg} + {{(ESUM_W-TERM_W+1){1'b0}}, term};

    assign len = ({{(COUNT_W-LOOK_W){1'b0}}, look_ahead_reg} > COUNT_W'(MAX_WINDOW))
               ? COUNT_W'(MAX_WINDOW) : {{(COUNT_W-LOOK_W){1'b0}}, look_ahead_reg};
    assign n_terms = (count_reg < len) ? CNT_W'(count_reg) : CNT_W'(len);

    assign ptr_inc = (ptr_reg == IDX_W'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    assign rd_dec  = (rd_reg == '0) ? IDX_W'(MAX_WINDOW - 1) : rd_reg - 1'b1;

    always_comb
    begin
        case (k_reg)
            RT_STOP: q_sel = (rel_tol_reg > eps_floor_reg) ? rel_tol_reg : eps_floor_reg;
            RT_MIN:  q_sel = min_tol_reg;
            RT_VAN:  q_sel = eps_floor_reg;
            default: q_sel = '0;
        endcase
    end

    // lhs * 2^64 against the accumulated 128-bit product
    assign cmp_lhs = (k_reg == RT_VAN) ? {24'd0, step_reg, 8'd0}
                                       : {{(64-WSUM_W){1'b0}}, wsum_reg};
    assign cmp_lt  = (cmp_lhs < acc[127:64]) || ((cmp_lhs == acc[127:64]) && (acc[63:0] != '0));

    assign stop_flag = (count_reg > max_steps_reg)
                    || ((count_reg > len) && flags_reg[RT_STOP]);
    assign min_flag  = (count_reg >= len) && flags_reg[RT_MIN];
    assign van_flag  = flags_reg[RT_VAN] && ({16'd0, step_reg, 16'd0} < acc[63:0]);

    always_comb
    begin
        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !req.req_type)
                begin
                    mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                    mac_a  = req.alpha;
                    mac_b  = req.r_pinv_r;
                end
            end
            ST_SQ:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                mac_a  = q_sel;
                mac_b  = q_sel;
            end
            ST_SQL:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                mac_a  = acc[31:0];
                mac_b  = energy_reg[31:0];
            end
            ST_P1:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_32};
                mac_a  = sq_reg[31:0];
                mac_b  = energy_reg[63:32];
            end
            ST_P2:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_32};
                mac_a  = sq_reg[63:32];
                mac_b  = energy_reg[31:0];
            end
            ST_P3:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_64};
                mac_a  = sq_reg[63:32];
                mac_b  = energy_reg[63:32];
            end
            ST_ABS:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                mac_a  = abs_tol_reg;
                mac_b  = abs_tol_reg;
            end
            default:
            begin
                mac_op = '0;
            end
        endcase
    end

    // ring storage, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD)
        begin
            ring[ptr_reg] <= term;
        end
        if (state_reg == ST_WSUM)
        begin
            rd_data_reg <= ring[rd_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= RT_STOP;
            flags_reg      <= '0;
            rel_tol_reg    <= RST_REL_TOL;
            eps_floor_reg  <= RST_EPS_FLOOR;
            abs_tol_reg    <= RST_ABS_TOL;
            max_steps_reg  <= RST_MAX_STEPS;
            look_ahead_reg <= RST_LOOK_AHEAD;
            min_tol_reg    <= RST_MIN_TOL;
            ptr_reg        <= '0;
            rd_reg         <= '0;
            pend_reg       <= 1'b0;
            issued_reg     <= '0;
            wsum_reg       <= '0;
            energy_reg     <= '0;
            step_reg       <= '0;
            count_reg      <= '0;
            sq_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_stop_reg   <= 1'b0;
            out_van_reg    <= 1'b0;
            out_min_reg    <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REL_TOL:    rel_tol_reg    <= cfg_data;
                    CFG_EPS_FLOOR:  eps_floor_reg  <= cfg_data;
                    CFG_ABS_TOL:    abs_tol_reg    <= cfg_data;
                    CFG_MAX_STEPS:  max_steps_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_LOOK_AHEAD: look_ahead_reg <= cfg_data[LOOK_W-1:0];
                    CFG_MIN_TOL:    min_tol_reg    <= cfg_data;
                    default:        ;
                endcase
            end

            if (rsp.valid && rsp.ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.req_type)
                        begin
                            ptr_reg    <= '0;
                            wsum_reg   <= '0;
                            energy_reg <= '0;
                            count_reg  <= '0;
                            k_reg      <= RT_STOP;
                            state_reg  <= ST_SQ;
                        end
                        else
                        begin
                            step_reg  <= req.q_aq[DATA_W-1] ? (~req.q_aq + 1'b1) : req.q_aq;
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_UPD:
                begin
                    rd_reg     <= ptr_reg;
                    ptr_reg    <= ptr_inc;
                    energy_reg <= energy_sum[ESUM_W] ? '1 : energy_sum[ESUM_W-1:0];
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    wsum_reg   <= '0;
                    issued_reg <= '0;
                    pend_reg   <= 1'b0;
                    state_reg  <= ST_WSUM;
                end
                ST_WSUM:
                begin
                    // read newest first; each entry is registered, then added in the next cycle
                    if (pend_reg)
                    begin
                        wsum_reg <= wsum_reg + {{(WSUM_W-TERM_W){1'b0}}, rd_data_reg};
                    end
                    if (issued_reg != n_terms)
                    begin
                        issued_reg <= issued_reg + 1'b1;
                        rd_reg     <= rd_dec;
                        pend_reg   <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            k_reg     <= RT_STOP;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SQL;
                end
                ST_SQL:
                begin
                    sq_reg    <= acc[63:0];
                    state_reg <= ST_P1;
                end
                ST_P1:
                begin
                    state_reg <= ST_P2;
                end
                ST_P2:
                begin
                    state_reg <= ST_P3;
                end
                ST_P3:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    flags_reg[k_reg] <= cmp_lt;
                    case (k_reg)
                        RT_STOP:
                        begin
                            k_reg     <= RT_MIN;
                            state_reg <= ST_SQ;
                        end
                        RT_MIN:
                        begin
                            k_reg     <= RT_VAN;
                            state_reg <= ST_SQ;
                        end
                        default:
                        begin
                            state_reg <= ST_ABS;
                        end
                    endcase
                end
                ST_ABS:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_stop_reg  <= stop_flag;
                        out_van_reg   <= van_flag;
                        out_min_reg   <= min_flag;
                        out_count_reg <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.stop                 = out_stop_reg;
    assign rsp.vanishing_step       = out_van_reg;
    assign rsp.min_decrease_reached = out_min_reg;
    assign rsp.iteration_count      = out_count_reg;
endmodule

// ===== verif/cgee_flag_checker.sv =====
// checker for the cg energy-error stop check: rebuilds the estimator state from the
// accepted requests and register writes, and compares every response transaction
// depends on cgee_pkg, cgee_req_if and cgee_rsp_if

module cgee_flag_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    cgee_req_if                             req,
    cgee_rsp_if                             rsp,
    input  logic                            cfg_we,
    input  logic [cgee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgee_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import cgee_pkg::*;

    localparam logic CLEAR_REQ = 1'b1;

    typedef struct packed {
        logic               stop;
        logic               vanishing;
        logic               min_decrease;
        logic [COUNT_W-1:0] count;
    } flag_set_t;

    logic [DATA_W-1:0]  rel_tol;
    logic [DATA_W-1:0]  eps_floor;
    logic [DATA_W-1:0]  abs_tol;
    logic [DATA_W-1:0]  min_tol;
    logic [COUNT_W-1:0] max_steps;
    logic [LOOK_W-1:0]  look_ahead;

    logic [TERM_W-1:0]  terms [MAX_WINDOW];
    int                 slot;
    logic [WSUM_W-1:0]  window_sum;
    logic [ESUM_W-1:0]  energy;
    logic [DATA_W-1:0]  step_len;
    logic [COUNT_W-1:0] term_count;

    flag_set_t          flags_due [$];
    int                 err_cnt;

    assign errors = err_cnt;

    // window / energy below (tol / 2^32)^2, cross-multiplied
    function automatic logic ratio_below(input logic [DATA_W-1:0] tol);
        logic [63:0]  tol_sq;
        logic [127:0] lhs;
        logic [127:0] rhs;
        tol_sq = {32'b0, tol} * {32'b0, tol};
        lhs    = {4'b0, window_sum, 64'b0};
        rhs    = {64'b0, tol_sq} * {64'b0, energy};
        return lhs < rhs;
    endfunction

    function automatic flag_set_t next_flags(input logic              kind,
                                             input logic [DATA_W-1:0] alpha,
                                             input logic [DATA_W-1:0] q_aq,
                                             input logic [DATA_W-1:0] rpr);
        flag_set_t         res;
        logic [63:0]       prod;
        logic [64:0]       e_next;
        logic [63:0]       w_acc;
        logic [63:0]       eps_sq;
        logic [63:0]       abs_sq;
        logic [63:0]       step_w;
        logic [127:0]      lhs;
        logic [127:0]      rhs;
        logic [DATA_W-1:0] tol;
        int                span;
        int                n;
        int                i;
        span = int'(look_ahead);
        if (span > MAX_WINDOW)
        begin
            span = MAX_WINDOW;
        end
        if (kind == CLEAR_REQ)
        begin
            slot       = 0;
            window_sum = '0;
            energy     = '0;
            term_count = '0;
        end
        else
        begin
            prod        = {32'b0, alpha} * {32'b0, rpr};
            terms[slot] = prod[63:8];
            slot        = (slot + 1) % MAX_WINDOW;
            e_next      = {1'b0, energy} + {9'b0, prod[63:8]};
            energy      = e_next[64] ? '1 : e_next[63:0];
            step_len    = q_aq[DATA_W-1] ? -q_aq : q_aq;
            if (term_count != '1)
            begin
                term_count = term_count + 1'b1;
            end
            n = (int'(term_count) < span) ? int'(term_count) : span;
            w_acc = '0;
            for (i = 0; i < n; i++)
            begin
                w_acc = w_acc + {8'b0, terms[(slot + 2 * MAX_WINDOW - 1 - i) % MAX_WINDOW]};
            end
            window_sum = w_acc[WSUM_W-1:0];
        end

        tol              = (rel_tol > eps_floor) ? rel_tol : eps_floor;
        res.count        = term_count;
        res.stop         = (term_count > max_steps)
                           || (int'(term_count) > span && ratio_below(tol));
        res.min_decrease = (int'(term_count) >= span) && ratio_below(min_tol);

        eps_sq = {32'b0, eps_floor} * {32'b0, eps_floor};
        abs_sq = {32'b0, abs_tol} * {32'b0, abs_tol};
        step_w = {32'b0, step_len};
        lhs    = {step_w << 8, 64'b0};
        rhs    = {64'b0, eps_sq} * {64'b0, energy};
        res.vanishing = (lhs < rhs) && ((step_w << 16) < abs_sq);
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        err_cnt++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        flag_set_t got;
        flag_set_t want;
        if (!rst_n)
        begin
            rel_tol    = RST_REL_TOL;
            eps_floor  = RST_EPS_FLOOR;
            abs_tol    = RST_ABS_TOL;
            max_steps  = RST_MAX_STEPS;
            look_ahead = RST_LOOK_AHEAD;
            min_tol    = RST_MIN_TOL;
            foreach (terms[k])
            begin
                terms[k] = '0;
            end
            slot       = 0;
            window_sum = '0;
            energy     = '0;
            step_len   = '0;
            term_count = '0;
            flags_due.delete();
            err_cnt    = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REL_TOL:    rel_tol    = cfg_data;
                    CFG_EPS_FLOOR:  eps_floor  = cfg_data;
                    CFG_ABS_TOL:    abs_tol    = cfg_data;
                    CFG_MAX_STEPS:  max_steps  = cfg_data[COUNT_W-1:0];
                    CFG_LOOK_AHEAD: look_ahead = cfg_data[LOOK_W-1:0];
                    CFG_MIN_TOL:    min_tol    = cfg_data;
                    default:        ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                got.stop         = rsp.stop;
                got.vanishing    = rsp.vanishing_step;
                got.min_decrease = rsp.min_decrease_reached;
                got.count        = rsp.iteration_count;
                if (flags_due.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected response transaction, expected none %s %0d",
                             $time, "actual count", got.count);
                end
                else
                begin
                    want = flags_due.pop_front();
                    if (got.stop !== want.stop)
                        note_mismatch("stop", 32'(want.stop), 32'(got.stop));
                    if (got.vanishing !== want.vanishing)
                        note_mismatch("vanishing_step", 32'(want.vanishing),
                                      32'(got.vanishing));
                    if (got.min_decrease !== want.min_decrease)
                        note_mismatch("min_decrease_reached", 32'(want.min_decrease),
                                      32'(got.min_decrease));
                    if (got.count !== want.count)
                        note_mismatch("iteration_count", 32'(want.count), 32'(got.count));
                end
            end

            if (req.valid && req.ready)
            begin
                flags_due.insert(flags_due.size(),
                                 next_flags(req.req_type, req.alpha, req.q_aq, req.r_pinv_r));
            end
            pending <= flags_due.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// top of the stop check testbench: clock, reset, register writes and request stimulus
// with random idling on both channels; the verdict comes from cgee_flag_checker
// depends on cgee_pkg, cgee_req_if, cgee_rsp_if, cg_energy_error_stop_check and the checker

module tb;
    import cgee_pkg::*;

    localparam logic                 REQ_UPDATE = 1'b0;
    localparam logic                 REQ_CLEAR  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam logic [31:0]          ALL_ONES   = 32'hFFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_total;
    int                    flags_pending;
    int                    items_sent;
    bit                    gaps_on = 1'b1;

    cgee_req_if req_ch ();
    cgee_rsp_if rsp_ch ();

    cg_energy_error_stop_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cgee_flag_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (err_total),
        .pending   (flags_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= 15);
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] alpha,
                             input logic [31:0] curv, input logic [31:0] rpr);
        while (gaps_on && $urandom_range(99) < 15)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.alpha    <= alpha;
        req_ch.q_aq     <= curv;
        req_ch.r_pinv_r <= rpr;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (flags_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] rel, input logic [31:0] eps,
                                 input logic [31:0] abs_acc, input logic [31:0] steps,
                                 input logic [31:0] look, input logic [31:0] mtol,
                                 input bit stray);
        hold_until_drained();
        repeat (4) @(posedge clk);
        write_reg(CFG_REL_TOL, rel);
        write_reg(CFG_EPS_FLOOR, eps);
        write_reg(CFG_ABS_TOL, abs_acc);
        write_reg(CFG_MAX_STEPS, steps);
        write_reg(CFG_LOOK_AHEAD, look);
        write_reg(CFG_MIN_TOL, mtol);
        if (stray)
        begin
            write_reg(CFG_NO_REG, $urandom);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_fraction();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom;
            default: return $urandom >> $urandom_range(0, 24);
        endcase
    endfunction

    initial
    begin
        int          phase;
        int          target;
        int          len;
        int          j;
        int          a_sh;
        int          r_sh;
        int          a_rate;
        int          r_rate;
        logic [31:0] steps;
        logic [31:0] look;
        logic [31:0] curv;
        bit          drained;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_UPDATE;
        req_ch.alpha    <= '0;
        req_ch.q_aq     <= '0;
        req_ch.r_pinv_r <= '0;
        items_sent       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: clear on fresh state, zero energy, extreme terms
        send_item(REQ_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(REQ_UPDATE, '0, '0, '0);
        send_item(REQ_UPDATE, ALL_ONES, 32'h8000_0000, ALL_ONES);
        send_item(REQ_UPDATE, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(REQ_UPDATE, 32'h0001_0000, ALL_ONES, 32'h0000_0100);

        // all tolerances at full scale, no window, immediate forced stop
        load_settings(ALL_ONES, ALL_ONES, ALL_ONES, '0, '0, ALL_ONES, 1'b0);
        send_item(REQ_UPDATE, 32'h0001_0000, '0, 32'h0001_0000);
        send_item(REQ_UPDATE, ALL_ONES, 32'd1, ALL_ONES);
        send_item(REQ_UPDATE, '0, '0, '0);
        send_item(REQ_CLEAR, '0, '0, '0);
        send_item(REQ_UPDATE, 32'h0010_0000, 32'h0000_0010, 32'h0000_1000);

        // zero tolerances, look-ahead above the window, stray register index
        load_settings('0, '0, '0, 32'd1048574, 32'd31, '0, 1'b1);
        for (j = 0; j < 5; j++)
        begin
            send_item(REQ_UPDATE, ALL_ONES >> (j * 6), 32'h0100_0000 >> j, ALL_ONES >> (j * 5));
        end

        // short window decaying to zero terms, then past max_steps
        load_settings(32'h8000_0000, 32'h0000_1000, 32'h0100_0000, 32'd3, 32'd2,
                      32'h4000_0000, 1'b0);
        send_item(REQ_CLEAR, '0, '0, '0);
        send_item(REQ_UPDATE, 32'h0100_0000, 32'hFFFF_0000, 32'h0100_0000);
        send_item(REQ_UPDATE, 32'h0000_1000, 32'h0000_0100, 32'h0000_1000);
        send_item(REQ_UPDATE, '0, '0, 32'h0001_0000);
        send_item(REQ_UPDATE, '0, 32'hFFFF_FFFF, '0);
        send_item(REQ_UPDATE, 32'h0000_0001, '0, 32'h0000_00FF);

        for (phase = 0; phase < 20; phase++)
        begin
            gaps_on = !(phase == 8 || phase == 9);
            case ($urandom_range(4))
                0:       steps = '0;
                1:       steps = $urandom_range(1, 30);
                2:       steps = 32'd1048574;
                3:       steps = $urandom | 32'h000F_FFFF;
                default: steps = $urandom_range(20, 300);
            endcase
            case ($urandom_range(5))
                0:       look = '0;
                1:       look = 32'd16;
                2:       look = $urandom_range(17, 31);
                3:       look = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 15);
                default: look = $urandom_range(1, 16);
            endcase
            load_settings(pick_fraction(), pick_fraction(), pick_fraction(), steps, look,
                          pick_fraction(), phase % 5 == 0);

            target  = items_sent + 80;
            drained = 1'b0;
            while (items_sent < target)
            begin
                // one descent: a clear, then terms shrinking at a random rate
                len    = ($urandom_range(5) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 24);
                a_sh   = $urandom_range(0, 10);
                r_sh   = $urandom_range(0, 10);
                a_rate = $urandom_range(0, 3);
                r_rate = $urandom_range(0, 2);
                send_item(REQ_CLEAR, $urandom, $urandom, $urandom);
                for (j = 0; j < len; j++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        send_item($urandom_range(1) != 0, $urandom, $urandom, $urandom);
                    end
                    else
                    begin
                        curv = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(1) != 0)
                        begin
                            curv = -curv;
                        end
                        send_item(REQ_UPDATE, $urandom >> (a_sh + j * a_rate), curv,
                                  $urandom >> (r_sh + j * r_rate));
                    end
                end
                if (!drained && $urandom_range(2) == 0)
                begin
                    hold_until_drained();
                    drained = 1'b1;
                end
            end
        end

        hold_until_drained();
        repeat (40) @(posedge clk);
        if (err_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cgee_pkg.sv
src/cgee_req_if.sv
src/cgee_rsp_if.sv
src/cgee_mac.sv
src/cg_energy_error_stop_check.sv
verif/cgee_flag_checker.sv
verif/tb.sv
